### hw/rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// CRT merge package
// Shared widths and the divider request/response structs.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MOD_BITS  = 31;
  localparam int OUT_BITS  = 2 * MOD_BITS;
  // Wide work width: signed values up to about 2^63 in magnitude.
  localparam int WIDE_BITS = OUT_BITS + 2;
  localparam int IN_BYTES  = (4 * MOD_BITS + 7) / 8;
  localparam int OUT_BYTES = (1 + 2 * OUT_BITS + 7) / 8;
  localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

  // Request to the shared restoring divider (unsigned operands).
  typedef struct packed {
    logic                 start;
    logic [WIDE_BITS-1:0] dividend;
    logic [WIDE_BITS-1:0] divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic                 done;
    logic [WIDE_BITS-1:0] quotient;
    logic [WIDE_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

### hw/rtl/crt_divider.sv
// ----------------------------------------------------------------------------
// CRT shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crt_divider (
  input  logic              clk,
  input  logic              rst,
  input  crt_pkg::div_req_t req,
  output crt_pkg::div_rsp_t rsp
);

  logic [crt_pkg::WIDE_BITS-1:0] quo;
  logic [crt_pkg::WIDE_BITS-1:0] rem;
  logic [crt_pkg::WIDE_BITS-1:0] dsr;
  logic [crt_pkg::CNT_BITS-1:0]  cnt;
  logic                          busy;
  logic                          done;
  logic [crt_pkg::WIDE_BITS:0]   trial;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem, quo[crt_pkg::WIDE_BITS-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= crt_pkg::CNT_BITS'(crt_pkg::WIDE_BITS);
      end else if (busy) begin
        if (trial[crt_pkg::WIDE_BITS]) begin
          rem <= {rem[crt_pkg::WIDE_BITS-2:0], quo[crt_pkg::WIDE_BITS-1]};
          quo <= {quo[crt_pkg::WIDE_BITS-2:0], 1'b0};
        end else begin
          rem <= trial[crt_pkg::WIDE_BITS-1:0];
          quo <= {quo[crt_pkg::WIDE_BITS-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == crt_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### hw/rtl/crt_merge_two_congruences.sv
// ----------------------------------------------------------------------------
// CRT merge of two congruences
// Generalized Chinese remainder merge with extended Euclid.
// ----------------------------------------------------------------------------
// One request takes one divider pass per Euclid quotient step, then five more
// divisions and the final multiplications. The time is set by the single
// bit-serial divider that every quotient and remainder goes through. A zero
// modulus skips all of this and goes straight to the output register. The
// block takes no new request until the result has been taken from the
// output register.
module crt_merge_two_congruences (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // residue_a, modulus_a, residue_b, modulus_b (low to high)
  input  logic [crt_pkg::IN_BYTES*8-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // solvable, combined_residue, combined_modulus (low to high)
  output logic [crt_pkg::OUT_BYTES*8-1:0] m_tdata
);

  localparam int MB = crt_pkg::MOD_BITS;
  localparam int WB = crt_pkg::WIDE_BITS;
  localparam int OB = crt_pkg::OUT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EU_DIV, ST_EU_MUL, ST_EU_UPD, ST_DIFF, ST_NDIV,
    ST_UMOD, ST_QMOD, ST_KMUL, ST_KMOD, ST_RES, ST_OUT
  } state_t;

  state_t state;
  logic [MB-1:0] ra, ma, rb, mb;
  logic signed [WB-1:0] r0, r1, s0, s1, qv, prod;
  logic signed [WB-1:0] diff, nval, uu, qq;
  logic neg;
  logic solv;
  logic [OB-1:0] res_out, mod_out;
  crt_pkg::div_req_t dreq;
  crt_pkg::div_rsp_t drsp;
  logic [WB-1:0] mag_rem;
  logic [2*MB-1:0] kprod, mprod, lprod;

  crt_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Remainder with the sign of the dividend mapped into [0, n).
  assign mag_rem = (neg && drsp.remainder != '0) ? WB'(nval) - drsp.remainder
                                                 : drsp.remainder;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(crt_pkg::OUT_BYTES*8-1-2*OB){1'b0}}, mod_out, res_out, solv};

  // Full-width products of the reduced 31-bit operands.
  assign kprod = mag_rem[MB-1:0] * uu[MB-1:0];
  assign mprod = ma * drsp.remainder[MB-1:0];
  assign lprod = ma * nval[MB-1:0];

  // Sequencer around the shared divider; products are 32x32 or narrower.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          ra <= s_tdata[MB-1:0];
          ma <= s_tdata[2*MB-1:MB];
          rb <= s_tdata[3*MB-1:2*MB];
          mb <= s_tdata[4*MB-1:3*MB];
          r0 <= WB'(s_tdata[2*MB-1:MB]);
          r1 <= WB'(s_tdata[4*MB-1:3*MB]);
          s0 <= WB'(1);
          s1 <= '0;
          solv    <= 1'b0;
          res_out <= '0;
          mod_out <= OB'(s_tdata[2*MB-1:MB]);
          if (s_tdata[2*MB-1:MB] == '0 || s_tdata[4*MB-1:3*MB] == '0) begin
            state <= ST_OUT;
          end else begin
            dreq.start    <= 1'b1;
            dreq.dividend <= WB'(s_tdata[2*MB-1:MB]);
            dreq.divisor  <= WB'(s_tdata[4*MB-1:3*MB]);
            state         <= ST_EU_DIV;
          end
        end
        ST_EU_DIV: if (drsp.done) begin
          qv    <= drsp.quotient;
          r0    <= r1;
          r1    <= drsp.remainder;
          state <= ST_EU_MUL;
        end
        ST_EU_MUL: begin
          // Quotient and coefficient both fit in 32 bits.
          prod  <= WB'(signed'(qv[MB:0]) * signed'(s1[MB:0]));
          state <= ST_EU_UPD;
        end
        ST_EU_UPD: begin
          s0 <= s1;
          s1 <= s0 - prod;
          if (r1 != '0) begin
            dreq.start    <= 1'b1;
            dreq.dividend <= r0;
            dreq.divisor  <= r1;
            state         <= ST_EU_DIV;
          end else begin
            // r0 = g, s0 (after update) = u.
            diff  <= WB'(rb) - WB'(ra);
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          neg           <= diff[WB-1];
          dreq.start    <= 1'b1;
          dreq.dividend <= diff[WB-1] ? -diff : diff;
          dreq.divisor  <= r0;
          state         <= ST_NDIV;
          qq            <= '0;
        end
        ST_NDIV: if (drsp.done) begin
          if (drsp.remainder != '0) begin
            state <= ST_OUT;
          end else begin
            qq            <= neg ? -drsp.quotient : drsp.quotient;
            dreq.start    <= 1'b1;
            dreq.dividend <= WB'(mb);
            dreq.divisor  <= r0;
            state         <= ST_UMOD;
          end
        end
        ST_UMOD: if (drsp.done) begin
          nval          <= drsp.quotient;
          neg           <= s0[WB-1];
          dreq.start    <= 1'b1;
          dreq.dividend <= s0[WB-1] ? -s0 : s0;
          dreq.divisor  <= drsp.quotient;
          state         <= ST_QMOD;
        end
        ST_QMOD: if (drsp.done) begin
          uu            <= mag_rem;
          neg           <= qq[WB-1];
          dreq.start    <= 1'b1;
          dreq.dividend <= qq[WB-1] ? -qq : qq;
          dreq.divisor  <= nval;
          state         <= ST_KMUL;
        end
        ST_KMUL: if (drsp.done) begin
          prod  <= WB'(kprod);
          state <= ST_KMOD;
        end
        ST_KMOD: begin
          neg           <= 1'b0;
          dreq.start    <= 1'b1;
          dreq.dividend <= prod;
          dreq.divisor  <= nval;
          state         <= ST_RES;
        end
        ST_RES: if (drsp.done) begin
          res_out <= mprod + OB'(ra);
          mod_out <= lprod;
          solv    <= 1'b1;
          state   <= ST_OUT;
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("ready while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OB:1] == '0))
    else $error("residue set without a solution");

endmodule

### tb/crt_merge_two_congruences_tb.sv
// ----------------------------------------------------------------------------
// CRT merge testbench
// Drives congruence pairs into the merge block over the input stream, predicts
// each merged result with a behavioral extended Euclid, and checks the output
// stream field by field, with random idling on both sides in all but the last run.
// ----------------------------------------------------------------------------
module crt_merge_two_congruences_tb;

  typedef struct packed {
    logic                         solvable;
    logic [crt_pkg::OUT_BITS-1:0] residue;
    logic [crt_pkg::OUT_BITS-1:0] modulus;
  } merge_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [crt_pkg::IN_BYTES*8-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [crt_pkg::OUT_BYTES*8-1:0] m_tdata;

  merge_t merge_q[$];
  int mismatches;
  int results_seen;
  int solvable_seen;
  int requests_sent;
  bit send_idle_en;
  bit recv_idle_en;

  crt_merge_two_congruences dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Signed 64-bit remainder reduced into [0, n).
  function automatic longint reduce_pos(longint v, longint n);
    longint r;
    r = v % n;
    if (r < 0) r += n;
    return r;
  endfunction

  // Behavioral merge of the two congruences.
  function automatic merge_t predict_merge(longint ra, longint ma, longint rb, longint mb);
    merge_t   m;
    longint   r0, r1, s0, s1, quo, tr, ts, g, n, diff;
    bit [63:0] k, prod;
    m.solvable = 1'b0;
    m.residue  = '0;
    m.modulus  = crt_pkg::OUT_BITS'(ma);
    if (ma == 0 || mb == 0) return m;
    r0 = ma; r1 = mb; s0 = 1; s1 = 0;
    while (r1 != 0) begin
      quo = r0 / r1;
      tr = r0 - quo * r1;
      ts = s0 - quo * s1;
      r0 = r1; r1 = tr; s0 = s1; s1 = ts;
    end
    g = r0;
    diff = rb - ra;
    if (diff % g != 0) return m;
    n = mb / g;
    k = 64'(reduce_pos(diff / g, n)) * 64'(reduce_pos(s0, n));
    k = k % 64'(n);
    prod = 64'(ra) + 64'(ma) * k;
    m.solvable = 1'b1;
    m.residue  = prod[crt_pkg::OUT_BITS-1:0];
    prod = 64'(ma) * 64'(n);
    m.modulus  = prod[crt_pkg::OUT_BITS-1:0];
    return m;
  endfunction

  // Random idle burst when enabled.
  task automatic idle_burst(bit en);
    if (en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  // Send one request and queue its expected result.
  task automatic send_request(bit [crt_pkg::MOD_BITS-1:0] ra, bit [crt_pkg::MOD_BITS-1:0] ma,
                              bit [crt_pkg::MOD_BITS-1:0] rb, bit [crt_pkg::MOD_BITS-1:0] mb);
    idle_burst(send_idle_en);
    s_tdata  = {{(crt_pkg::IN_BYTES*8-4*crt_pkg::MOD_BITS){1'b0}}, mb, rb, ma, ra};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    merge_q.push_back(predict_merge(ra, ma, rb, mb));
    requests_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Wait until every expected result has come back, or give up at a guard limit.
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (merge_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // Random modulus: mostly small so Euclid stays short, some full width.
  function automatic bit [crt_pkg::MOD_BITS-1:0] rand_mod();
    case ($urandom_range(0, 9))
      0: return crt_pkg::MOD_BITS'($urandom_range(1, 2147483647));
      1: return crt_pkg::MOD_BITS'($urandom_range(0, 2));
      default: return crt_pkg::MOD_BITS'($urandom_range(1, 5000));
    endcase
  endfunction

  // Random residue, sometimes not below its modulus.
  function automatic bit [crt_pkg::MOD_BITS-1:0] rand_res(bit [crt_pkg::MOD_BITS-1:0] m);
    if ($urandom_range(0, 7) == 0 || m == 0)
      return crt_pkg::MOD_BITS'($urandom_range(0, 2147483647));
    return crt_pkg::MOD_BITS'($urandom_range(0, m - 1));
  endfunction

  // Extremes of the fields and the special cases.
  task automatic test_directed();
    bit [crt_pkg::MOD_BITS-1:0] mx;
    mx = '1;
    send_request(0, 1, 0, 1);
    send_request(2, 3, 3, 5);
    send_request(1, 4, 2, 6);          // incompatible congruences
    send_request(1, 4, 3, 6);          // compatible, shared factor
    send_request(0, 0, 5, 7);          // zero first modulus
    send_request(3, 7, 5, 0);          // zero second modulus
    send_request(0, 0, 0, 0);
    send_request(mx, mx, mx, mx);      // residues not below moduli
    send_request(mx - 1, mx, 0, mx - 1);
    send_request(mx - 1, mx, mx - 2, mx - 2);
    send_request(12, 5, 40, 3);
    send_request(mx, 1, 0, mx);
    send_request(5, 10, 5, 10);        // equal congruences
    send_request(5, 10, 6, 10);
    send_request(123456789, 2147483629, 987654321, 2147483587);
    send_request(1836311903, 1836311903, 0, 1134903170); // long Euclid chain
    send_request(0, 1 << 30, 1 << 29, 3 << 29);
  endtask

  // Mostly compatible pairs built from a shared solution, plus raw noise.
  task automatic test_random(int count);
    bit [crt_pkg::MOD_BITS-1:0] ma, mb, t;
    for (int i = 0; i < count; i++) begin
      ma = rand_mod();
      mb = rand_mod();
      if ($urandom_range(0, 2) != 0 && ma != 0 && mb != 0) begin
        t = crt_pkg::MOD_BITS'($urandom());
        send_request(t % ma, ma, t % mb, mb);
      end else begin
        send_request(rand_res(ma), ma, rand_res(mb), mb);
      end
    end
  endtask

  // Receiver stall control.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    merge_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[crt_pkg::OUT_BITS:1],
             m_tdata[2*crt_pkg::OUT_BITS:crt_pkg::OUT_BITS+1]};
      results_seen++;
      if (merge_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", m_tdata);
      end else begin
        want = merge_q.pop_front();
        if (got.solvable) solvable_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: solvable %b/%b residue %0d/%0d modulus %0d/%0d (exp/got)",
                     want.solvable, got.solvable, want.residue, got.residue,
                     want.modulus, got.modulus);
        end
      end
    end
  end

  initial begin
    #1000000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mismatches = 0;
    results_seen = 0;
    solvable_seen = 0;
    requests_sent = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random(1400);
    wait_drained();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(230);
    wait_drained();
    repeat (50) @(negedge clk);
    if (merge_q.size() != 0) mismatches++;
    $display("Sent %0d congruence pairs, %0d results checked, %0d of them solvable.",
             requests_sent, results_seen, solvable_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
